// ----- design/chi_pkg.sv -----
// chi_pkg: types and constants shared by the channel intensity histogram
// modules. No dependencies.
`timescale 1ns / 1ps
package chi_pkg;

   // pixel component and bin index width of the request fields, channel sum and result value widths
   localparam int PIXEL_BITS    = 8;
   localparam int SUM_BITS      = 10;
   localparam int VALUE_BITS    = 32;
   // widest bin address any supported histogram size needs
   localparam int MAX_BIN_BITS  = 12;

   // gray average: floor(sum / 3) == (sum * 683) >> 11 for every sum up to 765
   localparam int GRAY_RECIP    = 683;
   localparam int GRAY_SHIFT    = 11;
   localparam int PROD_BITS     = 20;

   // command queue between front and back
   localparam int QUEUE_DEPTH   = 4;
   localparam int QUEUE_PTR_BITS = 2;

   // request function codes
   localparam logic FUNC_PIXEL  = 1'b0;
   localparam logic FUNC_READ   = 1'b1;

   // result kind codes
   localparam logic KIND_BIN    = 1'b0;
   localparam logic KIND_TOTAL  = 1'b1;

   // source mode codes
   localparam logic [1:0] MODE_GRAY  = 2'd0;
   localparam logic [1:0] MODE_RED   = 2'd1;
   localparam logic [1:0] MODE_GREEN = 2'd2;
   localparam logic [1:0] MODE_BLUE  = 2'd3;

   // classified request as it travels from front to back
   typedef struct packed {
      logic                        func;
      logic                        last;
      logic                        in_range;
      logic [PIXEL_BITS-1:0]       raw_bin;
      logic [MAX_BIN_BITS-1:0]     addr;
   } chi_cmd_type;

   // back status seen by the front
   typedef struct packed {
      logic clearing;
   } chi_status_type;

   typedef enum logic [1:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_UPDATE
   } chi_back_state_type;

endpackage

// ----- design/chi_front.sv -----
// chi_front: accepts requests, works out the bin address and holds the
// classified request in one stage until the queue takes it. Uses chi_pkg.
`timescale 1ns / 1ps
module chi_front
   import chi_pkg::*;
#(
   parameter int NUM_BINS = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic                  req_func,
   input  logic [PIXEL_BITS-1:0] req_red,
   input  logic [PIXEL_BITS-1:0] req_green,
   input  logic [PIXEL_BITS-1:0] req_blue,
   input  logic                  req_last_pixel,
   input  logic [PIXEL_BITS-1:0] req_read_bin,
   input  logic [1:0]            source_mode,
   input  chi_status_type        status,
   output logic                  cmd_valid,
   input  logic                  cmd_ready,
   output chi_cmd_type           cmd
);

   logic                   stage_valid_ff;
   logic                   stage_valid_in;
   chi_cmd_type            stage_ff;
   chi_cmd_type            stage_in;
   logic                   accept;
   logic [SUM_BITS-1:0]    sum;
   logic [PROD_BITS-1:0]   prod;
   logic [PIXEL_BITS-1:0]  gray;
   logic [PIXEL_BITS-1:0]  idx;

   // stalled while the store is cleared or the stage cannot drain
   assign req_full = status.clearing || (stage_valid_ff && !cmd_ready);
   assign accept   = req_push && !req_full;

   // gray average by reciprocal multiply
   assign sum  = SUM_BITS'(req_red) + SUM_BITS'(req_green) + SUM_BITS'(req_blue);
   assign prod = PROD_BITS'(sum) * PROD_BITS'(GRAY_RECIP);
   assign gray = prod[GRAY_SHIFT +: PIXEL_BITS];

   // source selection
   always_comb begin
      case (source_mode)
         MODE_GRAY:  idx = gray;
         MODE_RED:   idx = req_red;
         MODE_GREEN: idx = req_green;
         MODE_BLUE:  idx = req_blue;
         default:    idx = gray;
      endcase
   end

   // classify the request
   always_comb begin
      stage_in          = stage_ff;
      stage_valid_in    = stage_valid_ff && !cmd_ready;
      if (accept) begin
         stage_valid_in    = 1'b1;
         stage_in.func     = req_func;
         stage_in.last     = req_last_pixel;
         stage_in.raw_bin  = req_read_bin;
         if (req_func == FUNC_READ) begin
            stage_in.in_range = (32'(req_read_bin) < 32'(NUM_BINS));
            stage_in.addr     = MAX_BIN_BITS'(req_read_bin);
         end else begin
            stage_in.in_range = 1'b1;
            if (32'(idx) >= 32'(NUM_BINS)) begin
               stage_in.addr = MAX_BIN_BITS'(NUM_BINS - 1);
            end else begin
               stage_in.addr = MAX_BIN_BITS'(idx);
            end
         end
      end
   end

   // stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
      stage_ff <= stage_in;
   end

   assign cmd_valid = stage_valid_ff;
   assign cmd       = stage_ff;

endmodule

// ----- design/chi_queue.sv -----
// chi_queue: short queue of classified requests between front and back.
// Uses chi_pkg.
`timescale 1ns / 1ps
module chi_queue
   import chi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        wr_valid,
   output logic        wr_ready,
   input  chi_cmd_type wr_cmd,
   output logic        rd_valid,
   input  logic        rd_pop,
   output chi_cmd_type rd_cmd
);

   chi_cmd_type                entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]  wr_ptr_ff;
   logic [QUEUE_PTR_BITS-1:0]  rd_ptr_ff;
   logic [QUEUE_PTR_BITS:0]    count_ff;
   logic                       do_write;
   logic                       do_read;

   assign wr_ready = (count_ff != (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_cmd   = entries_ff[rd_ptr_ff];
   assign do_write = wr_valid && wr_ready;
   assign do_read  = rd_pop && rd_valid;

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_write) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_read) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_write && !do_read) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_read && !do_write) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_write) begin
         entries_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

endmodule

// ----- design/chi_back.sv -----
// chi_back: bin store, frame counter and result register. Runs the clearing
// pass after reset, then one read-modify-write per request. Uses chi_pkg.
`timescale 1ns / 1ps
module chi_back
   import chi_pkg::*;
#(
   parameter int NUM_BINS   = 256,
   parameter int COUNT_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   output logic                  q_pop,
   input  chi_cmd_type           q_cmd,
   output chi_status_type        status,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [VALUE_BITS-1:0] rsp_value,
   output logic                  rsp_kind,
   output logic [PIXEL_BITS-1:0] rsp_result_bin
);

   localparam int BIN_BITS = $clog2(NUM_BINS);

   chi_back_state_type      state_ff, state_in;
   logic [BIN_BITS-1:0]     clr_ff, clr_in;
   chi_cmd_type             cmd_ff, cmd_in;
   logic [COUNT_BITS-1:0]   frame_ff, frame_in;
   logic                    out_valid_ff, out_valid_in;
   logic [VALUE_BITS-1:0]   out_value_ff, out_value_in;
   logic                    out_kind_ff, out_kind_in;
   logic [PIXEL_BITS-1:0]   out_bin_ff, out_bin_in;

   logic [COUNT_BITS-1:0]   store [NUM_BINS];
   logic [COUNT_BITS-1:0]   rd_data_ff;
   logic [BIN_BITS-1:0]     rd_addr;
   logic                    wr_en;
   logic [BIN_BITS-1:0]     wr_addr;
   logic [COUNT_BITS-1:0]   wr_data;

   logic [COUNT_BITS-1:0]   bin_inc;
   logic [COUNT_BITS-1:0]   frame_inc;
   logic [63:0]             bin_wide;
   logic [63:0]             frame_wide;
   logic [VALUE_BITS-1:0]   bin_val;
   logic [VALUE_BITS-1:0]   frame_val;

   // saturating increments
   assign bin_inc   = (rd_data_ff == '1) ? rd_data_ff : rd_data_ff + COUNT_BITS'(1);
   assign frame_inc = (frame_ff == '1) ? frame_ff : frame_ff + COUNT_BITS'(1);

   // clip counts to the result width
   assign bin_wide   = 64'(rd_data_ff);
   assign frame_wide = 64'(frame_inc);
   assign bin_val    = (|bin_wide[63:VALUE_BITS]) ? '1 : bin_wide[VALUE_BITS-1:0];
   assign frame_val  = (|frame_wide[63:VALUE_BITS]) ? '1 : frame_wide[VALUE_BITS-1:0];

   // next state and datapath control
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      cmd_in       = cmd_ff;
      frame_in     = frame_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_value_in = out_value_ff;
      out_kind_in  = out_kind_ff;
      out_bin_in   = out_bin_ff;
      q_pop        = 1'b0;
      rd_addr      = q_cmd.addr[BIN_BITS-1:0];
      wr_en        = 1'b0;
      wr_addr      = clr_ff;
      wr_data      = '0;
      case (state_ff)
         BK_CLEAR: begin
            wr_en = 1'b1;
            if (clr_ff == BIN_BITS'(NUM_BINS - 1)) begin
               state_in = BK_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         BK_IDLE: begin
            if (q_valid && (!out_valid_ff || rsp_pop)) begin
               q_pop    = 1'b1;
               cmd_in   = q_cmd;
               state_in = BK_UPDATE;
            end
         end
         BK_UPDATE: begin
            wr_addr  = cmd_ff.addr[BIN_BITS-1:0];
            state_in = BK_IDLE;
            if (cmd_ff.func == FUNC_READ) begin
               wr_en        = cmd_ff.in_range;
               wr_data      = '0;
               out_valid_in = 1'b1;
               out_value_in = cmd_ff.in_range ? bin_val : '0;
               out_kind_in  = KIND_BIN;
               out_bin_in   = cmd_ff.raw_bin;
            end else begin
               wr_en   = 1'b1;
               wr_data = bin_inc;
               if (cmd_ff.last) begin
                  frame_in     = '0;
                  out_valid_in = 1'b1;
                  out_value_in = frame_val;
                  out_kind_in  = KIND_TOTAL;
                  out_bin_in   = '0;
               end else begin
                  frame_in = frame_inc;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         clr_ff       <= '0;
         frame_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         frame_ff     <= frame_in;
         out_valid_ff <= out_valid_in;
      end
      cmd_ff       <= cmd_in;
      out_value_ff <= out_value_in;
      out_kind_ff  <= out_kind_in;
      out_bin_ff   <= out_bin_in;
   end

   // bin store, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store[wr_addr] <= wr_data;
      end
      rd_data_ff <= store[rd_addr];
   end

   assign status.clearing = (state_ff == BK_CLEAR);
   assign rsp_empty       = !out_valid_ff;
   assign rsp_value       = out_value_ff;
   assign rsp_kind        = out_kind_ff;
   assign rsp_result_bin  = out_bin_ff;

endmodule

// ----- design/channel_intensity_histogram.sv -----
// channel_intensity_histogram: top level of the intensity histogram.
// Depends on chi_pkg, chi_front, chi_queue and chi_back.
//
//   channel   ports                         direction  accepted when
//   request   req_push / req_full / fields  in         req_push & !req_full
//   response  rsp_empty / rsp_pop / fields  out        rsp_pop & !rsp_empty
//   csr       csr_we / csr_wdata            in         csr_we
//
// In the back end a request takes a registered read of the bin store and a
// write-back; the back end takes no new request before it is through with the
// last one. The front stage and the four-entry queue absorb bursts. A result
// passes the front stage, the queue, the read and write-back states and the
// result register. After reset the bin store is cleared one bin a cycle with
// req_full high. A waiting response holds its result and stops the back end
// from taking the next request until it is popped.
`timescale 1ns / 1ps
module channel_intensity_histogram
   import chi_pkg::*;
#(
   parameter int NUM_BINS   = 256,
   parameter int COUNT_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic                  req_func,
   input  logic [PIXEL_BITS-1:0] req_red,
   input  logic [PIXEL_BITS-1:0] req_green,
   input  logic [PIXEL_BITS-1:0] req_blue,
   input  logic                  req_last_pixel,
   input  logic [PIXEL_BITS-1:0] req_read_bin,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [VALUE_BITS-1:0] rsp_value,
   output logic                  rsp_kind,
   output logic [PIXEL_BITS-1:0] rsp_result_bin,
   input  logic                  csr_we,
   input  logic [1:0]            csr_wdata
);

   logic [1:0]      source_mode_ff;
   chi_status_type  status;
   logic            f_valid;
   logic            f_ready;
   chi_cmd_type     f_cmd;
   logic            q_valid;
   logic            q_pop;
   chi_cmd_type     q_cmd;

   // source mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         source_mode_ff <= MODE_GRAY;
      end else if (csr_we) begin
         source_mode_ff <= csr_wdata;
      end
   end

   chi_front #(
      .NUM_BINS (NUM_BINS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_func       (req_func),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .req_last_pixel (req_last_pixel),
      .req_read_bin   (req_read_bin),
      .source_mode    (source_mode_ff),
      .status         (status),
      .cmd_valid      (f_valid),
      .cmd_ready      (f_ready),
      .cmd            (f_cmd)
   );

   chi_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (f_valid),
      .wr_ready (f_ready),
      .wr_cmd   (f_cmd),
      .rd_valid (q_valid),
      .rd_pop   (q_pop),
      .rd_cmd   (q_cmd)
   );

   chi_back #(
      .NUM_BINS   (NUM_BINS),
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_pop          (q_pop),
      .q_cmd          (q_cmd),
      .status         (status),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_value      (rsp_value),
      .rsp_kind       (rsp_kind),
      .rsp_result_bin (rsp_result_bin)
   );

endmodule

// ----- design/chi_checker.sv -----
// chi_checker: port-level checks on the intensity histogram, bound to the
// top level. Depends on chi_pkg and channel_intensity_histogram.
`timescale 1ns / 1ps
module chi_checker
   import chi_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_full,
   input logic                  rsp_empty,
   input logic                  rsp_pop,
   input logic [VALUE_BITS-1:0] rsp_value,
   input logic                  rsp_kind,
   input logic [PIXEL_BITS-1:0] rsp_result_bin
);

   // a waiting result holds until it is taken
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_value) && $stable(rsp_kind) && $stable(rsp_result_bin)))
      else $error("response changed while stalled");

   // a frame total carries bin zero
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_kind == KIND_TOTAL)) |-> (rsp_result_bin == '0))
      else $error("frame total with non-zero bin");

   // the clearing pass blocks requests right after reset
   assert property (@(posedge clock)
      reset |=> req_full)
      else $error("request accepted during clearing pass");

   // no result is waiting right after reset
   assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("response present after reset");

endmodule

bind channel_intensity_histogram chi_checker u_chi_checker (.*);
